### src/glyph_lru_cache_defines.svh
// ----------------------------------------------------------------------------
// Glyph cache assertion macros
// Check macros used at the end of the cache module; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef GLYPH_LRU_CACHE_DEFINES_SVH
`define GLYPH_LRU_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define GLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define GLC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define GLC_ASSERT(lbl, prop, msg)
`define GLC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### src/glc_pkg.sv
// ----------------------------------------------------------------------------
// Glyph cache package
// Sizes, beat types, stored entry layout and controller states.
// ----------------------------------------------------------------------------
package glc_pkg;
	localparam int CAPACITY = 64;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic OP_FIND = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [20:0] code_point;
		logic [7:0]  font_id;
		logic [15:0] image_handle;
		logic [9:0]  glyph_advance;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] found_handle;
		logic [9:0]  found_advance;
		logic        evicted;
		logic [15:0] evicted_handle;
	} rsp_t;

	// age: recency rank, 0 most recent; ins: insertion rank, 0 newest
	typedef struct packed {
		logic [20:0]      code;
		logic [7:0]       font;
		logic [15:0]      handle;
		logic [9:0]       advance;
		logic [IDX_W-1:0] age;
		logic [IDX_W-1:0] ins;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_UPD  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;
endpackage

### src/glc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module glc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	clk,
	we,
	waddr,
	wdata,
	raddr,
	rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	input  logic             clk;
	input  logic             we;
	input  logic [AW-1:0]    waddr;
	input  logic [WIDTH-1:0] wdata;
	input  logic [AW-1:0]    raddr;
	output logic [WIDTH-1:0] rdata;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/glyph_lru_cache.sv
// Font 0 requests go straight to the response; a find miss takes a scan pass, an add
// with a free slot an update pass, and a find hit or a full add a scan pass then an
// update pass, one entry per cycle through the RAM.
// One request in flight; the next is accepted from the cycle in which rsp_valid
// rises, or later while the previous response still waits.
// Reset clears the entry count and control; entry RAM contents need no clear.
// ----------------------------------------------------------------------------
// Glyph LRU cache
// Fully associative glyph cache in one entry RAM, scanned and updated per beat.
// ----------------------------------------------------------------------------
`include "glyph_lru_cache_defines.svh"

module glyph_lru_cache (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  glc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output glc_pkg::rsp_t rsp
);
	import glc_pkg::*;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rd_q;
	logic [CNT_W-1:0]  end_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	req_t              req_q;
	logic              hit_q;
	logic              ev_q;
	logic [IDX_W-1:0]  bidx_q;
	logic [IDX_W-1:0]  bage_q;
	logic [IDX_W-1:0]  bins_q;
	logic [15:0]       bhandle_q;
	logic [9:0]        badv_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              issue;
	logic              we;
	entry_t            rd_e;
	entry_t            wr_e;
	logic [ENTRY_W-1:0] rdata;
	logic              key_match;
	logic              pass_done;

	assign issue     = ((state_q == S_SCAN) || (state_q == S_UPD)) && (rd_q < end_q);
	assign pass_done = !issue && !pend_s1;
	assign we        = (state_q == S_UPD) && pend_s1;
	assign rd_e      = entry_t'(rdata);
	assign key_match = (rd_e.code == req_q.code_point) && (rd_e.font == req_q.font_id);

	glc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(idx_s1),
		.wdata(ENTRY_W'(wr_e)),
		.raddr(rd_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	// modify the entry read last cycle
	always_comb begin
		wr_e = rd_e;
		if (req_q.opcode == OP_FIND) begin
			if (idx_s1 == bidx_q) begin
				wr_e.age = '0;
			end else if (rd_e.age < bage_q) begin
				wr_e.age = rd_e.age + IDX_W'(1);
			end
		end else if (idx_s1 == bidx_q) begin
			wr_e.code    = req_q.code_point;
			wr_e.font    = req_q.font_id;
			wr_e.handle  = req_q.image_handle;
			wr_e.advance = req_q.glyph_advance;
			wr_e.age     = '0;
			wr_e.ins     = '0;
		end else begin
			wr_e.age = rd_e.age + IDX_W'(1);
			if (!ev_q || (rd_e.ins < bins_q)) begin
				wr_e.ins = rd_e.ins + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_q        <= '0;
			end_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			ev_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (issue) begin
				rd_q <= rd_q + CNT_W'(1);
			end
			if ((state_q == S_DONE) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						hit_q <= 1'b0;
						ev_q  <= 1'b0;
						rd_q  <= '0;
						if (req.font_id == 8'd0) begin
							state_q <= S_DONE;
						end else if (req.opcode == OP_FIND) begin
							end_q   <= cnt_q;
							state_q <= S_SCAN;
						end else if (cnt_q == CNT_W'(CAPACITY)) begin
							ev_q    <= 1'b1;
							end_q   <= cnt_q;
							state_q <= S_SCAN;
						end else begin
							end_q   <= cnt_q + CNT_W'(1);
							state_q <= S_UPD;
						end
					end
				end
				S_SCAN: begin
					if (pend_s1) begin
						if (req_q.opcode == OP_FIND) begin
							if (key_match && (!hit_q || (rd_e.ins < bins_q))) begin
								hit_q <= 1'b1;
							end
						end else if (!hit_q || (rd_e.age >= bage_q)) begin
							hit_q <= 1'b1;
						end
					end
					if (pass_done) begin
						rd_q <= '0;
						if ((req_q.opcode == OP_FIND) && !hit_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					if (pass_done) begin
						if ((req_q.opcode == OP_ADD) && !ev_q) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: request hold, best match / victim capture, result
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			req_q  <= req;
			bidx_q <= cnt_q[IDX_W-1:0];
		end
		if ((state_q == S_SCAN) && pend_s1) begin
			if (((req_q.opcode == OP_FIND) && key_match && (!hit_q || (rd_e.ins < bins_q)))
				|| ((req_q.opcode == OP_ADD) && (!hit_q || (rd_e.age >= bage_q)))) begin
				bidx_q    <= idx_s1;
				bage_q    <= rd_e.age;
				bins_q    <= rd_e.ins;
				bhandle_q <= rd_e.handle;
				badv_q    <= rd_e.advance;
			end
		end
		if (issue) begin
			idx_s1 <= rd_q[IDX_W-1:0];
		end
		if ((state_q == S_DONE) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.hit            <= (req_q.opcode == OP_FIND) && hit_q;
			rsp_q.found_handle   <= ((req_q.opcode == OP_FIND) && hit_q) ? bhandle_q : 16'd0;
			rsp_q.found_advance  <= ((req_q.opcode == OP_FIND) && hit_q) ? badv_q : 10'd0;
			rsp_q.evicted        <= ev_q;
			rsp_q.evicted_handle <= ev_q ? bhandle_q : 16'd0;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`GLC_ASSERT(a_cnt_range, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`GLC_ASSERT(a_idle_quiet, (state_q == S_IDLE) |-> !pend_s1, "read pending while idle")
	`GLC_ASSERT_NEXT(a_upd_done, (state_q == S_UPD) && pass_done, state_q == S_DONE, "update pass did not finish")
	`GLC_ASSERT_NEXT(a_cnt_idle, state_q == S_IDLE, cnt_q == $past(cnt_q), "count moved outside update")
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph cache testbench
// Drives find and add requests with random idling on both channels and checks
// every response against a model of the entry store that tracks recency ranks.
// ----------------------------------------------------------------------------

class glyph_scoreboard;
	glc_pkg::rsp_t pending[$];
	logic [20:0]   st_code[$];
	logic [7:0]    st_font[$];
	logic [15:0]   st_handle[$];
	logic [9:0]    st_adv[$];
	int            st_age[$];
	int            errors;
	int            hits, evicts, rsps;

	function void note_request(glc_pkg::req_t r);
		glc_pkg::rsp_t e;
		int victim, n;
		e = '0;
		n = st_code.size();
		if (r.font_id != 0) begin
			if (r.opcode == glc_pkg::OP_FIND) begin
				for (int i = n - 1; i >= 0; i--) begin
					if (st_code[i] == r.code_point && st_font[i] == r.font_id) begin
						e.hit = 1'b1;
						e.found_handle = st_handle[i];
						e.found_advance = st_adv[i];
						for (int j = 0; j < n; j++)
							if (j != i && st_age[j] < st_age[i])
								st_age[j]++;
						st_age[i] = 0;
						break;
					end
				end
			end else begin
				if (n >= glc_pkg::CAPACITY) begin
					victim = 0;
					for (int i = 0; i < n; i++)
						if (st_age[i] >= st_age[victim])
							victim = i;
					e.evicted = 1'b1;
					e.evicted_handle = st_handle[victim];
					st_code.delete(victim);
					st_font.delete(victim);
					st_handle.delete(victim);
					st_adv.delete(victim);
					st_age.delete(victim);
				end
				foreach (st_age[i])
					st_age[i]++;
				st_code.push_back(r.code_point);
				st_font.push_back(r.font_id);
				st_handle.push_back(r.image_handle);
				st_adv.push_back(r.glyph_advance);
				st_age.push_back(0);
			end
		end
		pending.push_back(e);
	endfunction

	function void check_response(glc_pkg::rsp_t a);
		glc_pkg::rsp_t e;
		rsps++;
		if (pending.size() == 0) begin
			$display("%0t: unexpected response %h", $time, a);
			errors++;
			return;
		end
		e = pending.pop_front();
		hits += a.hit;
		evicts += a.evicted;
		if (a.hit !== e.hit || a.found_handle !== e.found_handle ||
				a.found_advance !== e.found_advance || a.evicted !== e.evicted ||
				a.evicted_handle !== e.evicted_handle) begin
			$display("%0t: mismatch expected hit=%b h=%h adv=%h ev=%b evh=%h",
				$time, e.hit, e.found_handle, e.found_advance, e.evicted, e.evicted_handle);
			$display("%0t:          actual hit=%b h=%h adv=%h ev=%b evh=%h",
				$time, a.hit, a.found_handle, a.found_advance, a.evicted, a.evicted_handle);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import glc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 0;
	longint cycles = 0;
	glyph_scoreboard sb;
	req_t keys[$];

	glyph_lru_cache dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stall and a long hold-off window
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
		end
	end

	// drop valid only while idling, so back-to-back beats keep it high
	task automatic send(req_t r);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	function automatic req_t rand_req();
		req_t r;
		r.opcode = 1'($urandom_range(1));
		r.image_handle = 16'($urandom);
		r.glyph_advance = 10'($urandom);
		if (keys.size() > 0 && $urandom_range(99) < 60) begin
			// reuse a known key to get hits and touch recency
			r.code_point = keys[$urandom_range(keys.size() - 1)].code_point;
			r.font_id = keys[$urandom_range(keys.size() - 1)].font_id;
			if ($urandom_range(1))
				r.font_id = keys[$urandom_range(keys.size() - 1)].font_id;
		end else begin
			r.code_point = ($urandom_range(9) == 0) ? 21'h10FFFF :
				21'($urandom_range(21'h10FFFF));
			r.font_id = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(255));
		end
		if ($urandom_range(2) == 0)
			r.code_point = 21'($urandom_range(7));
		if (r.opcode == OP_ADD) begin
			keys.push_back(r);
			if (keys.size() > 100)
				void'(keys.pop_front());
		end
		return r;
	endfunction

	task automatic mk(logic op, logic [20:0] c, logic [7:0] f, logic [15:0] h, logic [9:0] a);
		req_t r;
		r.opcode = op;
		r.code_point = c;
		r.font_id = f;
		r.image_handle = h;
		r.glyph_advance = a;
		send(r);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty miss, font zero, extremes, duplicates
		mk(OP_FIND, 21'd65, 8'd1, 16'h0, 10'h0);
		mk(OP_ADD, 21'd0, 8'd0, 16'hFFFF, 10'h3FF);
		mk(OP_FIND, 21'd0, 8'd0, 16'h0, 10'h0);
		mk(OP_ADD, 21'h10FFFF, 8'd255, 16'hFFFF, 10'h3FF);
		mk(OP_ADD, 21'd0, 8'd1, 16'h0000, 10'h000);
		mk(OP_FIND, 21'h10FFFF, 8'd255, 16'h0, 10'h0);
		mk(OP_FIND, 21'd0, 8'd1, 16'hFFFF, 10'h3FF);
		mk(OP_ADD, 21'd65, 8'd7, 16'h1111, 10'h111);
		mk(OP_ADD, 21'd65, 8'd7, 16'h2222, 10'h222);
		mk(OP_FIND, 21'd65, 8'd7, 16'h0, 10'h0);
		mk(OP_FIND, 21'd65, 8'd0, 16'h0, 10'h0);
		mk(OP_FIND, 21'd66, 8'd7, 16'h0, 10'h0);
		// fill past capacity to force evictions
		for (int i = 0; i < CAPACITY + 4; i++)
			mk(OP_ADD, 21'(1000 + i), 8'd9, 16'(16'h8000 + i), 10'(i));
		mk(OP_FIND, 21'd1010, 8'd9, 16'h0, 10'h0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 63; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 63; end
				3: begin send_idle = 27; recv_stall = 27; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			if (ph == 4) begin
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			repeat (200) send(rand_req());
		end
		req_valid <= 1'b0;

		while (sb.pending.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Ran %0d responses: %0d hits, %0d evictions, five idling phases.",
			sb.rsps, sb.hits, sb.evicts);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
